@@ sv/hmsc_pkg.sv @@
package hmsc_pkg;

  // Event kinds carried in s_tuser
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_KEY   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_SCAN  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_ENTRY = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  localparam logic [6:0] SEC_LIMIT  = 7'd60;
  localparam logic [6:0] MIN_LIMIT  = 7'd60;
  localparam logic [6:0] HOUR_LIMIT = 7'd24;
  localparam logic [2:0] ENTRY_LAST = 3'd5;
  localparam logic [2:0] SCAN_LAST  = 3'd5;
  localparam logic [7:0] KEY_ZERO   = 8'h30;
  localparam logic [7:0] KEY_NINE   = 8'h39;
  localparam logic [3:0] DIGIT_ONE  = 4'd1;
  localparam int         TOP_W      = 16;

  typedef struct packed {
    logic [6:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
  } clk_time_t;

  typedef struct packed {
    clk_time_t  tm;
    mode_t      mode;
    logic [2:0] digits;
    logic       elapsed;
  } core_res_t;

  // One pass of the carry chain; inputs are one bit wider so an increment cannot wrap
  function automatic clk_time_t carry_chain(input logic [7:0] s, input logic [7:0] m,
                                            input logic [7:0] h);
    logic [7:0] s_c;
    logic [7:0] m_c;
    logic [7:0] h_c;
    clk_time_t  r;
    s_c = s;
    m_c = m;
    h_c = h;
    if (s_c >= {1'b0, SEC_LIMIT}) begin
      s_c = '0;
      m_c = m_c + 8'd1;
    end
    if (m_c >= {1'b0, MIN_LIMIT}) begin
      m_c = '0;
      h_c = h_c + 8'd1;
    end
    if (h_c >= {1'b0, HOUR_LIMIT}) begin
      h_c = '0;
    end
    r.seconds = s_c[6:0];
    r.minutes = m_c[6:0];
    r.hours   = h_c[6:0];
    return r;
  endfunction

  // Common-anode seven-segment code, active low
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] c;
    unique case (d)
      4'd0:    c = 8'hC0;
      4'd1:    c = 8'hF9;
      4'd2:    c = 8'hA4;
      4'd3:    c = 8'hB0;
      4'd4:    c = 8'h99;
      4'd5:    c = 8'h92;
      4'd6:    c = 8'h82;
      4'd7:    c = 8'hF8;
      4'd8:    c = 8'h80;
      4'd9:    c = 8'h90;
      default: c = 8'hFF;
    endcase
    return c;
  endfunction

endpackage

@@ sv/hms_clock_with_entry_and_digit_scan.sv @@
// Channel   Dir  Word                        Fields (lowest bit first)
// s_axis    in   s_tdata[7:0], s_tuser[1:0]  keycode | func
// m_axis    out  m_tdata[47:0]               seconds, minutes, hours, mode, digits, elapsed,
//                                            digit_select_n, segment_drive, zero pad
// cfg       in   cfg_we, cfg_wdata[15:0]     ticks_per_second_top
//
// One word is taken every cycle while s_tready is high; a result reaches m_axis through the input
// register, which takes the word at the accepting edge, and then the result register, which
// takes the clock update.
// Core and scan state move only as the input register hands its word to the result register.
// rst is synchronous: time zero, awaiting the first key, prescaler top back to 46875.
// A stalled m side holds the result; the input register still fills, then s_tready drops.
module hms_clock_with_entry_and_digit_scan #(
  parameter int PRESCALE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] keycode
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [6:0] seconds_now, [13:7] minutes_now, [20:14] hours_now,
                                 // [22:21] mode_now, [25:23] digits_entered,
                                 // [26] second_elapsed, [32:27] digit_select_n,
                                 // [40:33] segment_drive, [47:41] zero
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import hmsc_pkg::*;

  logic        in_valid;
  func_t       in_func;
  logic [7:0]  in_key;
  logic        adv;
  logic [15:0] top;
  clk_time_t   tm_now;
  core_res_t   res_next;
  logic [5:0]  sel_n;
  logic [7:0]  seg;

  // Advance when a word waits and the result register is free or being emptied
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Hold the word payload; no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= func_t'(s_tuser);
      in_key  <= s_tdata;
    end
  end

  // Prescaler top; to be written only while idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= 16'd46875;
    end else if (cfg_we) begin
      top <= cfg_wdata;
    end
  end

  hmsc_core #(
    .PRESCALE_BITS(PRESCALE_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .func     (in_func),
    .keycode  (in_key),
    .top      (top),
    .tm_now   (tm_now),
    .res_next (res_next)
  );

  // Display decode reads the live time; a scan step leaves the time untouched
  hmsc_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .is_scan (in_func == FUNC_SCAN),
    .tm      (tm_now),
    .sel_n   (sel_n),
    .seg     (seg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {7'd0, seg, sel_n, res_next.elapsed, res_next.digits, res_next.mode,
                  res_next.tm.hours, res_next.tm.minutes, res_next.tm.seconds};
    end
  end

endmodule

@@ sv/hmsc_core.sv @@
module hmsc_core #(
  parameter int PRESCALE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  hmsc_pkg::func_t             func,
  input  logic [7:0]                  keycode,
  input  logic [hmsc_pkg::TOP_W-1:0]  top,
  output hmsc_pkg::clk_time_t         tm_now,
  output hmsc_pkg::core_res_t         res_next
);
  import hmsc_pkg::*;

  localparam int CMP_W = (PRESCALE_BITS > TOP_W) ? PRESCALE_BITS : TOP_W;

  logic [PRESCALE_BITS-1:0] presc;
  logic [PRESCALE_BITS-1:0] presc_next;
  clk_time_t                tm;
  clk_time_t                tm_next;
  mode_t                    mode;
  mode_t                    mode_next;
  logic [2:0]               pos;
  logic [2:0]               pos_next;
  logic [6:0]               ent_s, ent_m, ent_h;
  logic [6:0]               ent_s_next, ent_m_next, ent_h_next;
  logic                     elapsed;
  logic                     is_digit;
  logic [3:0]               digit;
  logic [6:0]               cur_field;
  logic [6:0]               new_field;
  logic                     wrap;

  assign is_digit = (keycode >= KEY_ZERO) && (keycode <= KEY_NINE);
  assign digit    = keycode[3:0];
  assign wrap     = CMP_W'(presc) >= CMP_W'(top);

  always_comb begin
    unique case (pos[2:1])
      2'd0:    cur_field = ent_s;
      2'd1:    cur_field = ent_m;
      default: cur_field = ent_h;
    endcase
    new_field = pos[0] ? (cur_field + {3'b000, digit}) : ({3'b000, digit} * 7'd10);
  end

  // Mode sequencing
  always_comb begin
    mode_next = mode;
    if (func == FUNC_KEY && is_digit) begin
      unique case (mode)
        MODE_WAIT:  mode_next = (digit == DIGIT_ONE) ? MODE_ENTRY : MODE_RUN;
        MODE_ENTRY: if (pos == ENTRY_LAST) begin
          mode_next = MODE_RUN;
        end
        default:    mode_next = mode;
      endcase
    end
  end

  // Time, prescaler and entry datapath
  always_comb begin
    tm_next    = tm;
    presc_next = presc;
    pos_next   = pos;
    ent_s_next = ent_s;
    ent_m_next = ent_m;
    ent_h_next = ent_h;
    elapsed    = 1'b0;
    unique case (func)
      FUNC_TICK: begin
        if (wrap) begin
          presc_next = '0;
          tm_next    = carry_chain({1'b0, tm.seconds} + 8'd1, {1'b0, tm.minutes},
                                   {1'b0, tm.hours});
          elapsed    = 1'b1;
        end else begin
          presc_next = presc + 1'b1;
        end
      end
      FUNC_KEY: begin
        if (is_digit && mode == MODE_ENTRY) begin
          unique case (pos[2:1])
            2'd0:    ent_s_next = new_field;
            2'd1:    ent_m_next = new_field;
            default: ent_h_next = new_field;
          endcase
          if (pos == ENTRY_LAST) begin
            // last digit lands in hours: load the entered time at once
            tm_next    = carry_chain({1'b0, ent_s}, {1'b0, ent_m}, {1'b0, new_field});
            presc_next = '0;
            pos_next   = '0;
          end else begin
            pos_next = pos + 3'd1;
          end
        end else if (is_digit && mode == MODE_WAIT && digit != DIGIT_ONE) begin
          tm_next = '0;
        end
      end
      FUNC_CLEAR: tm_next = '0;
      FUNC_SCAN:  tm_next = tm;
      default:    tm_next = tm;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      presc <= '0;
      tm    <= '0;
      mode  <= MODE_WAIT;
      pos   <= '0;
    end else if (adv) begin
      presc <= presc_next;
      tm    <= tm_next;
      mode  <= mode_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_s <= ent_s_next;
      ent_m <= ent_m_next;
      ent_h <= ent_h_next;
    end
  end

  assign tm_now           = tm;
  assign res_next.tm      = tm_next;
  assign res_next.mode    = mode_next;
  assign res_next.digits  = pos_next;
  assign res_next.elapsed = elapsed;

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= ENTRY_LAST)
    else $error("entry position beyond last digit");
  a_pos_mode: assert property (@(posedge clk) disable iff (rst)
    (pos != 3'd0) |-> (mode == MODE_ENTRY))
    else $error("entry progress outside entry mode");
  a_wrap_clr: assert property (@(posedge clk) disable iff (rst)
    (adv && elapsed) |=> (presc == '0))
    else $error("prescaler not cleared on second");
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (tm.seconds < SEC_LIMIT) && (tm.minutes < MIN_LIMIT) && (tm.hours < HOUR_LIMIT))
    else $error("live time out of range");

endmodule

@@ sv/hmsc_scan.sv @@
module hmsc_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                is_scan,
  input  hmsc_pkg::clk_time_t tm,
  output logic [5:0]          sel_n,
  output logic [7:0]          seg
);
  import hmsc_pkg::*;

  logic [2:0]  scan_pos;
  logic [2:0]  pos;
  logic [6:0]  v;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [3:0]  tens_mod;
  logic [6:0]  units;
  logic [3:0]  d;

  always_comb begin
    pos = (scan_pos > SCAN_LAST) ? 3'd0 : scan_pos;
    unique case (pos[2:1])
      2'd0:    v = tm.seconds;
      2'd1:    v = tm.minutes;
      default: v = tm.hours;
    endcase
    // divide by ten through the reciprocal 205/2048, exact for seven bits
    prod     = {8'd0, v} * 15'd205;
    tens     = prod[14:11];
    tens_mod = (tens >= 4'd10) ? (tens - 4'd10) : tens;
    units    = v - ({3'b000, tens} * 7'd10);
    d        = pos[0] ? tens_mod : units[3:0];
    if (is_scan) begin
      sel_n = ~(6'b000001 << pos);
      seg   = ~seg_code(d);
    end else begin
      sel_n = 6'h3F;
      seg   = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= '0;
    end else if (adv && is_scan) begin
      scan_pos <= (pos >= SCAN_LAST) ? 3'd0 : pos + 3'd1;
    end
  end

endmodule
